[src/glyph_to_framebuffer_renderer_assert.svh]
// Assertion macros used by the glyph renderer top level.
`ifndef GLYPH_TO_FRAMEBUFFER_RENDERER_ASSERT_SVH
`define GLYPH_TO_FRAMEBUFFER_RENDERER_ASSERT_SVH
`ifndef SYNTHESIS
`define GTFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GTFB_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define GTFB_ASSERT(lbl, prop, msg)
`define GTFB_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[src/gtfb_pkg.sv]
// Shared constants, codes and types of the glyph renderer.
package gtfb_pkg;
	localparam int GLYPH_COLUMNS = 6;
	localparam int GLYPH_ROWS    = 8;
	localparam int GLYPH_COUNT   = 256;
	localparam int ADDR_BITS     = 16;

	localparam int FONT_DEPTH = GLYPH_COLUMNS * GLYPH_COUNT;
	localparam int FONT_AW    = $clog2(FONT_DEPTH);
	localparam int COL_W      = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
	localparam int ROW_W      = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

	localparam int POS_W    = 11;
	localparam int X_W      = 10;
	localparam int XS_W     = POS_W + 1;
	localparam int WIDTH_W  = 11;
	localparam int STRIDE_W = 12;
	localparam int PROD_W   = POS_W + STRIDE_W + 1;
	localparam int CFG_W    = 12;
	localparam int OUT_W    = 16;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_SETX = 2'd1;
	localparam logic [1:0] KIND_SETY = 2'd2;
	localparam logic [1:0] KIND_DRAW = 2'd3;

	localparam logic [1:0] CFG_PIXEL_MODE = 2'd0;
	localparam logic [1:0] CFG_WIDTH      = 2'd1;
	localparam logic [1:0] CFG_STRIDE     = 2'd2;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd128;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd64;

	localparam logic [7:0]       MASK_LO = 8'h0f;
	localparam logic [7:0]       MASK_HI = 8'hf0;
	localparam logic [OUT_W-1:0] PIX_ON  = 16'hffff;
	localparam logic [OUT_W-1:0] PIX_OFF = 16'h0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BASE,
		ST_COL,
		ST_ROW
	} state_t;

	typedef struct packed {
		logic accept;
		logic start;
		logic fetch;
		logic advance;
		logic load_col;
		logic emit;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_draw;
		logic col_vis;
		logic col_end;
		logic row_end;
		logic out_free;
	} sts_t;
endpackage

[src/gtfb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module gtfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[src/gtfb_ctrl.sv]
// Sequencing state machine of the glyph renderer.
module gtfb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  gtfb_pkg::sts_t  sts,
	output gtfb_pkg::cmd_t  cmd
);
	gtfb_pkg::state_t state_q;
	gtfb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtfb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			gtfb_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.is_draw) begin
						cmd.start = 1'b1;
						state_d   = gtfb_pkg::ST_BASE;
					end
				end
			end
			gtfb_pkg::ST_BASE: begin
				cmd.fetch = 1'b1;
				state_d   = gtfb_pkg::ST_COL;
			end
			gtfb_pkg::ST_COL: begin
				// The font byte of the current column is valid in this state.
				if (sts.col_vis) begin
					cmd.load_col = 1'b1;
					state_d      = gtfb_pkg::ST_ROW;
				end else if (sts.col_end) begin
					cmd.finish = 1'b1;
					state_d    = gtfb_pkg::ST_IDLE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			gtfb_pkg::ST_ROW: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.row_end) begin
						if (sts.col_end) begin
							cmd.finish = 1'b1;
							state_d    = gtfb_pkg::ST_IDLE;
						end else begin
							cmd.advance = 1'b1;
							state_d     = gtfb_pkg::ST_COL;
						end
					end
				end
			end
			default: begin
				state_d = gtfb_pkg::ST_IDLE;
			end
		endcase
	end
endmodule

[src/gtfb_datapath.sv]
// Cursor, configuration, font store, address arithmetic and output register.
module gtfb_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gtfb_pkg::cmd_t                   cmd,
	output gtfb_pkg::sts_t                   sts,
	input  logic [1:0]                       kind,
	input  logic [10:0]                      font_address,
	input  logic [7:0]                       font_byte,
	input  logic signed [gtfb_pkg::POS_W-1:0] position,
	input  logic [7:0]                       character,
	input  logic                             cfg_write,
	input  logic [1:0]                       cfg_index,
	input  logic [gtfb_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic [gtfb_pkg::OUT_W-1:0]       byte_address,
	output logic [gtfb_pkg::OUT_W-1:0]       write_bits,
	output logic [gtfb_pkg::OUT_W-1:0]       bit_mask,
	output logic                             two_bytes,
	output logic                             last_write
);
	logic                                  mode_q;
	logic [gtfb_pkg::WIDTH_W-1:0]          width_q;
	logic [gtfb_pkg::STRIDE_W-1:0]         stride_q;
	logic signed [gtfb_pkg::POS_W-1:0]     cursor_x_q;
	logic signed [gtfb_pkg::POS_W-1:0]     cursor_y_q;
	logic [gtfb_pkg::FONT_AW-1:0]          glyph_base_q;
	logic signed [gtfb_pkg::XS_W-1:0]      x_q;
	logic [gtfb_pkg::COL_W-1:0]            col_q;
	logic [gtfb_pkg::ROW_W-1:0]            row_q;
	logic [gtfb_pkg::ADDR_BITS-1:0]        y_base_q;
	logic [gtfb_pkg::ADDR_BITS-1:0]        addr_q;
	logic                                  out_valid_q;

	logic [7:0]                            char_idx;
	logic [gtfb_pkg::FONT_AW-1:0]          glyph_base_d;
	logic signed [gtfb_pkg::PROD_W-1:0]    y_prod;
	logic [gtfb_pkg::ADDR_BITS-1:0]        x_off;
	logic [gtfb_pkg::WIDTH_W-1:0]          x_inc;
	logic                                  x_edge;
	logic [gtfb_pkg::COL_W-1:0]            col_sel;
	logic signed [gtfb_pkg::XS_W-1:0]      x_sum;
	logic                                  font_we;
	logic                                  font_re;
	logic [gtfb_pkg::FONT_AW-1:0]          font_raddr;
	logic [7:0]                            font_q;
	logic                                  lit;
	logic [7:0]                            mask4;

	// Codes beyond the glyph count wrap once; the code is below twice the count.
	assign char_idx = (32'(character) >= gtfb_pkg::GLYPH_COUNT) ?
		8'(32'(character) - gtfb_pkg::GLYPH_COUNT) : character;
	assign glyph_base_d = gtfb_pkg::FONT_AW'(32'(char_idx) * gtfb_pkg::GLYPH_COLUMNS);

	assign y_prod = gtfb_pkg::PROD_W'(cursor_y_q) *
		signed'(gtfb_pkg::PROD_W'({1'b0, stride_q}));

	assign x_off = mode_q ? gtfb_pkg::ADDR_BITS'({x_q[gtfb_pkg::X_W-1:0], 1'b0})
		: gtfb_pkg::ADDR_BITS'(x_q[gtfb_pkg::X_W-1:1]);

	// Visible columns form one run, so a column closes the run when the next x is clipped.
	assign x_inc  = gtfb_pkg::WIDTH_W'(x_q[gtfb_pkg::X_W-1:0]) + 1'b1;
	assign x_edge = (&x_q[gtfb_pkg::X_W-1:0]) || (x_inc >= width_q);

	assign sts.is_draw  = (kind == gtfb_pkg::KIND_DRAW);
	assign sts.col_vis  = !x_q[gtfb_pkg::XS_W-1] && !x_q[gtfb_pkg::X_W] &&
		(gtfb_pkg::WIDTH_W'(x_q[gtfb_pkg::X_W-1:0]) < width_q);
	assign sts.col_end  = (col_q == gtfb_pkg::COL_W'(gtfb_pkg::GLYPH_COLUMNS - 1));
	assign sts.row_end  = (row_q == gtfb_pkg::ROW_W'(gtfb_pkg::GLYPH_ROWS - 1));
	assign sts.out_free = !out_valid_q || !out_stall;

	assign col_sel    = cmd.advance ? col_q + 1'b1 : col_q;
	assign font_raddr = glyph_base_q + gtfb_pkg::FONT_AW'(col_sel);
	assign font_re    = cmd.fetch || cmd.advance;
	assign font_we    = cmd.accept && (kind == gtfb_pkg::KIND_LOAD) &&
		(32'(font_address) < gtfb_pkg::FONT_DEPTH);

	gtfb_ram #(
		.WIDTH (8),
		.DEPTH (gtfb_pkg::FONT_DEPTH)
	) u_font (
		.clk   (clk),
		.we    (font_we),
		.waddr (gtfb_pkg::FONT_AW'(font_address)),
		.wdata (font_byte),
		.re    (font_re),
		.raddr (font_raddr),
		.rdata (font_q)
	);

	assign lit   = font_q[row_q];
	assign mask4 = x_q[0] ? gtfb_pkg::MASK_LO : gtfb_pkg::MASK_HI;
	assign x_sum = gtfb_pkg::XS_W'(cursor_x_q) + gtfb_pkg::XS_W'(gtfb_pkg::GLYPH_COLUMNS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			width_q     <= gtfb_pkg::WIDTH_RESET;
			stride_q    <= gtfb_pkg::STRIDE_RESET;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					gtfb_pkg::CFG_PIXEL_MODE: mode_q   <= cfg_data[0];
					gtfb_pkg::CFG_WIDTH:      width_q  <= cfg_data[gtfb_pkg::WIDTH_W-1:0];
					gtfb_pkg::CFG_STRIDE:     stride_q <= cfg_data[gtfb_pkg::STRIDE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept && (kind == gtfb_pkg::KIND_SETX)) begin
				cursor_x_q <= position;
			end
			if (cmd.accept && (kind == gtfb_pkg::KIND_SETY)) begin
				cursor_y_q <= position;
			end
			if (cmd.finish) begin
				// Saturate at the rightmost representable column.
				if (!x_sum[gtfb_pkg::XS_W-1] && x_sum[gtfb_pkg::X_W]) begin
					cursor_x_q <= gtfb_pkg::POS_W'({gtfb_pkg::X_W{1'b1}});
				end else begin
					cursor_x_q <= x_sum[gtfb_pkg::POS_W-1:0];
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			glyph_base_q <= glyph_base_d;
			y_base_q     <= gtfb_pkg::ADDR_BITS'(y_prod);
			x_q          <= gtfb_pkg::XS_W'(cursor_x_q);
			col_q        <= '0;
		end else if (cmd.advance) begin
			x_q   <= x_q + 1'b1;
			col_q <= col_q + 1'b1;
		end
		if (cmd.load_col) begin
			addr_q <= y_base_q + x_off;
			row_q  <= '0;
		end else if (cmd.emit) begin
			addr_q <= addr_q + gtfb_pkg::ADDR_BITS'(stride_q);
			row_q  <= row_q + 1'b1;
		end
		if (cmd.emit) begin
			byte_address <= gtfb_pkg::OUT_W'(addr_q);
			two_bytes    <= mode_q;
			last_write   <= sts.row_end && (sts.col_end || x_edge);
			if (mode_q) begin
				write_bits <= lit ? gtfb_pkg::PIX_ON : gtfb_pkg::PIX_OFF;
				bit_mask   <= gtfb_pkg::PIX_ON;
			end else begin
				write_bits <= lit ? {8'h00, mask4} : gtfb_pkg::PIX_OFF;
				bit_mask   <= {8'h00, mask4};
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

[src/glyph_to_framebuffer_renderer.sv]
// Top level of the 6x8 glyph renderer: controller, datapath and checks.
// Font loads and cursor writes complete on acceptance and leave the controller idle. A draw
// passes a base state that fetches the first font column, then skips each clipped column
// and, for each visible column, loads its address and issues one framebuffer write per row,
// holding while the output register is full. The font RAM read and the single output
// register set the pace. Reset clears state, cursor and settings; the font store is
// not cleared and holds garbage until loaded.
`include "glyph_to_framebuffer_renderer_assert.svh"
module glyph_to_framebuffer_renderer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [10:0]                       font_address,
	input  logic [7:0]                        font_byte,
	input  logic signed [gtfb_pkg::POS_W-1:0] position,
	input  logic [7:0]                        character,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [gtfb_pkg::OUT_W-1:0]        byte_address,
	output logic [gtfb_pkg::OUT_W-1:0]        write_bits,
	output logic [gtfb_pkg::OUT_W-1:0]        bit_mask,
	output logic                              two_bytes,
	output logic                              last_write,
	input  logic                              cfg_write,
	input  logic [1:0]                        cfg_index,
	input  logic [gtfb_pkg::CFG_W-1:0]        cfg_data
);
	gtfb_pkg::cmd_t cmd;
	gtfb_pkg::sts_t sts;

	gtfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	gtfb_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.font_address (font_address),
		.font_byte    (font_byte),
		.position     (position),
		.character    (character),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.byte_address (byte_address),
		.write_bits   (write_bits),
		.bit_mask     (bit_mask),
		.two_bytes    (two_bytes),
		.last_write   (last_write)
	);

	`GTFB_ASSERT(a_emit_has_room, cmd.emit |-> sts.out_free, "write issued into a full output register")
	`GTFB_ASSERT(a_draw_blocks_input, cmd.start |=> in_stall, "input not held off during a draw")
	`GTFB_ASSERT(a_finish_frees_input, cmd.finish |=> !in_stall, "input still held after a draw")
	`GTFB_ASSERT_NEVER(a_no_column_overrun, cmd.advance && sts.col_end, "column past the glyph")
endmodule

[bench/tb_glyph_to_framebuffer_renderer.sv]
// Self-checking testbench for the 6x8 glyph renderer: font loads, cursor moves and draws.
`timescale 1ns / 100ps

module tb_glyph_to_framebuffer_renderer;
	import gtfb_pkg::*;

	localparam int CLOCK_HALF    = 6;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASE_ITEMS   = 69;
	localparam int BURSTS        = 3;
	localparam int X_LIMIT       = 1023;
	localparam logic MODE_NIBBLE = 1'b0;
	localparam logic MODE_WORD   = 1'b1;

	typedef struct packed {
		logic [OUT_W-1:0] address;
		logic [OUT_W-1:0] data;
		logic [OUT_W-1:0] mask;
		logic             wide;
		logic             last;
	} fb_write_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] kind;
	logic [10:0] font_address;
	logic [7:0] font_byte;
	logic signed [POS_W-1:0] position;
	logic [7:0] character;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_W-1:0] byte_address;
	logic [OUT_W-1:0] write_bits;
	logic [OUT_W-1:0] bit_mask;
	logic two_bytes;
	logic last_write;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// Predictor state: a private copy of the font, cursor and settings.
	logic [7:0] font_copy [FONT_DEPTH];
	bit font_known [FONT_DEPTH];
	int cur_x = 0;
	int cur_y = 0;
	logic pix_mode = MODE_NIBBLE;
	int line_width = 128;
	int line_stride = 64;
	fb_write_t expected_writes[$];

	int errors = 0;
	int items_sent = 0;
	int draws_sent = 0;
	int writes_checked = 0;
	int settings_used = 0;
	int setting_idx = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;

	glyph_to_framebuffer_renderer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.font_address (font_address),
		.font_byte    (font_byte),
		.position     (position),
		.character    (character),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_address (byte_address),
		.write_bits   (write_bits),
		.bit_mask     (bit_mask),
		.two_bytes    (two_bytes),
		.last_write   (last_write),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#CLOCK_HALF clk = 1'b1;
		#CLOCK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("glyph_to_framebuffer_renderer test failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic bit column_visible(input int x);
		return x >= 0 && x <= X_LIMIT && x < line_width;
	endfunction

	function automatic bit glyph_ready(input int ch);
		for (int c = 0; c < GLYPH_COLUMNS; c++) begin
			if (!font_known[ch * GLYPH_COLUMNS + c])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
			input logic [OUT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_writes
		fb_write_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_writes.size() == 0) begin
				$error("byte_address: expected no write, got %h", byte_address);
				errors++;
			end else begin
				want = expected_writes.pop_front();
				writes_checked++;
				check_field("byte_address", want.address, byte_address);
				check_field("write_bits", want.data, write_bits);
				check_field("bit_mask", want.mask, bit_mask);
				check_field("two_bytes", OUT_W'(want.wide), OUT_W'(two_bytes));
				check_field("last_write", OUT_W'(want.last), OUT_W'(last_write));
			end
		end
	end

	// Updates the private state for one accepted item and queues the writes a draw causes.
	task automatic render_item(input logic [1:0] k, input logic [10:0] fa, input logic [7:0] fb,
			input logic signed [POS_W-1:0] pos, input logic [7:0] ch);
		int x;
		int last_col;
		int glyph_base;
		int row_addr;
		logic [7:0] column_bits;
		fb_write_t w;
		case (k)
		KIND_LOAD: begin
			if (fa < FONT_DEPTH) begin
				font_copy[fa] = fb;
				font_known[fa] = 1'b1;
			end
		end
		KIND_SETX: cur_x = int'(pos);
		KIND_SETY: cur_y = int'(pos);
		KIND_DRAW: begin
			glyph_base = (ch % GLYPH_COUNT) * GLYPH_COLUMNS;
			last_col = -1;
			for (int c = 0; c < GLYPH_COLUMNS; c++) begin
				if (column_visible(cur_x + c))
					last_col = c;
			end
			for (int c = 0; c < GLYPH_COLUMNS; c++) begin
				x = cur_x + c;
				if (!column_visible(x))
					continue;
				column_bits = font_copy[glyph_base + c];
				row_addr = cur_y * line_stride + ((pix_mode == MODE_WORD) ? x * 2 : x / 2);
				for (int r = 0; r < GLYPH_ROWS; r++) begin
					w.address = row_addr[OUT_W-1:0];
					if (pix_mode == MODE_WORD) begin
						w.mask = PIX_ON;
						w.wide = 1'b1;
					end else begin
						// Even columns own the high nibble of the byte.
						w.mask = x[0] ? {8'h00, MASK_LO} : {8'h00, MASK_HI};
						w.wide = 1'b0;
					end
					w.data = column_bits[r] ? w.mask : PIX_OFF;
					w.last = (c == last_col) && (r == GLYPH_ROWS - 1);
					expected_writes.push_back(w);
					row_addr += line_stride;
				end
			end
			cur_x = (cur_x + GLYPH_COLUMNS > X_LIMIT) ? X_LIMIT : cur_x + GLYPH_COLUMNS;
		end
		endcase
	endtask

	task automatic send_item(input logic [1:0] k, input logic [10:0] fa, input logic [7:0] fb,
			input logic signed [POS_W-1:0] pos, input logic [7:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		font_address <= fa;
		font_byte <= fb;
		position <= pos;
		character <= ch;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		render_item(k, fa, fb, pos, ch);
		items_sent++;
		if (k == KIND_DRAW)
			draws_sent++;
	endtask

	task automatic load_glyph(input int ch, input logic [8*GLYPH_COLUMNS-1:0] columns);
		int addr;
		for (int c = 0; c < GLYPH_COLUMNS; c++) begin
			addr = ch * GLYPH_COLUMNS + c;
			send_item(KIND_LOAD, addr[10:0], columns[8*c +: 8], '0, '0);
		end
	endtask

	// A load or a fully clipped draw leaves nothing to wait for, so some margin follows.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
		CFG_PIXEL_MODE: pix_mode = value[0];
		CFG_WIDTH:      line_width = int'(value[WIDTH_W-1:0]);
		CFG_STRIDE:     line_stride = int'(value[STRIDE_W-1:0]);
		default: ;
		endcase
	endtask

	task automatic apply_setting(input int idx);
		logic m;
		int w;
		int s;
		case (idx % 9)
		0: begin m = MODE_WORD;   w = 1024; s = 2048; end
		1: begin m = MODE_NIBBLE; w = 1;    s = 1;    end
		2: begin m = MODE_NIBBLE; w = 1024; s = 0;    end
		3: begin m = MODE_WORD;   w = 0;    s = 64;   end
		4: begin m = MODE_NIBBLE; w = 1024; s = 2048; end
		5: begin m = MODE_WORD;   w = 1;    s = 1;    end
		6: begin m = MODE_NIBBLE; w = 200;  s = 40;   end
		7: begin m = MODE_WORD;   w = 1024; s = 0;    end
		default: begin
			m = 1'($urandom_range(1));
			w = $urandom_range(1024, 1);
			s = $urandom_range(2048, 1);
		end
		endcase
		write_reg(CFG_PIXEL_MODE, int'(m));
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_STRIDE, s);
		settings_used++;
	endtask

	function automatic logic [7:0] random_column();
		case ($urandom_range(3))
		0: return 8'h00;
		1: return 8'hff;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Cursor x values cluster round both clipping edges and the saturation point.
	function automatic int random_x();
		int x;
		case ($urandom_range(4))
		0: x = int'($urandom_range(2047)) - 1024;
		1: x = -int'($urandom_range(6));
		2: x = line_width - int'($urandom_range(7));
		3: x = 1017 + int'($urandom_range(6));
		default: x = $urandom_range(40);
		endcase
		return (x > X_LIMIT) ? X_LIMIT : x;
	endfunction

	function automatic int random_y();
		case ($urandom_range(3))
		0: return int'($urandom_range(2047)) - 1024;
		1: return $urandom_range(31);
		2: return -int'($urandom_range(8, 1));
		default: return $urandom_range(1) ? X_LIMIT : -1024;
		endcase
	endfunction

	function automatic int pick_loaded_glyph();
		int ch;
		repeat (20) begin
			ch = $urandom_range(GLYPH_COUNT - 1);
			if (glyph_ready(ch))
				return ch;
		end
		return $urandom_range(1) ? GLYPH_COUNT - 1 : 0;
	endfunction

	task automatic test_glyph_loads();
		load_glyph(0, {8'h5a, 8'ha5, 8'h80, 8'h01, 8'h00, 8'hff});
		load_glyph(GLYPH_COUNT - 1, {8'hff, 8'h00, 8'h01, 8'h80, 8'ha5, 8'h5a});
		// Addresses past the store must be dropped rather than folded back onto glyph zero.
		send_item(KIND_LOAD, 11'(FONT_DEPTH + 1), 8'hff, '0, '0);
		send_item(KIND_LOAD, 11'h7ff, 8'h00, '0, '0);
		send_item(KIND_DRAW, '0, '0, '0, 8'h00);
		send_item(KIND_DRAW, '0, '0, '0, 8'hff);
	endtask

	task automatic test_cursor_edges();
		send_item(KIND_SETX, '0, '0, POS_W'(-3), '0);
		send_item(KIND_DRAW, '0, '0, '0, 8'hff);
		send_item(KIND_SETX, '0, '0, POS_W'(125), '0);
		send_item(KIND_SETY, '0, '0, POS_W'(X_LIMIT), '0);
		send_item(KIND_DRAW, '0, '0, '0, 8'h00);
		send_item(KIND_SETX, '0, '0, POS_W'(-1024), '0);
		send_item(KIND_SETY, '0, '0, POS_W'(-1024), '0);
		send_item(KIND_DRAW, '0, '0, '0, 8'h00);
		send_item(KIND_SETX, '0, '0, POS_W'(X_LIMIT), '0);
		send_item(KIND_DRAW, '0, '0, '0, 8'hff);
	endtask

	// Mostly whole glyph loads, cursor moves and draws, with stray single-byte loads as noise.
	task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
			input int n_items);
		int first;
		int pick;
		int addr;
		logic [8*GLYPH_COLUMNS-1:0] columns;
		send_idle_pct = sender_pct;
		recv_stall_pct = receiver_pct;
		for (int b = 0; b < BURSTS; b++) begin
			wait_idle();
			apply_setting(setting_idx);
			setting_idx++;
			first = items_sent;
			while (items_sent - first < n_items / BURSTS) begin
				pick = $urandom_range(99);
				if (pick < 15) begin
					for (int c = 0; c < GLYPH_COLUMNS; c++)
						columns[8*c +: 8] = random_column();
					load_glyph($urandom_range(GLYPH_COUNT - 1), columns);
				end else if (pick < 22) begin
					addr = $urandom_range(2047);
					send_item(KIND_LOAD, addr[10:0], 8'($urandom_range(255)), '0, '0);
				end else if (pick < 37) begin
					send_item(KIND_SETX, '0, '0, POS_W'(random_x()), '0);
				end else if (pick < 47) begin
					send_item(KIND_SETY, '0, '0, POS_W'(random_y()), '0);
				end else begin
					send_item(KIND_DRAW, '0, '0, '0, 8'(pick_loaded_glyph()));
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_LOAD;
		font_address = '0;
		font_byte = '0;
		position = '0;
		character = '0;
		cfg_write = 1'b0;
		cfg_index = CFG_PIXEL_MODE;
		cfg_data = '0;
		for (int i = 0; i < FONT_DEPTH; i++) begin
			font_copy[i] = 8'h00;
			font_known[i] = 1'b0;
		end
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 18;
		recv_stall_pct = 49;
		test_glyph_loads();
		test_cursor_edges();
		test_random_traffic(18, 49, PHASE_ITEMS);
		test_random_traffic(49, 18, PHASE_ITEMS);
		test_random_traffic(0, 0, PHASE_ITEMS);
		wait_idle();

		$display("Sent %0d items including %0d draws under %0d register settings.",
			items_sent, draws_sent, settings_used);
		$display("Checked %0d framebuffer writes across three idle patterns.", writes_checked);
		if (errors == 0 && expected_writes.size() == 0) begin
			$display("glyph_to_framebuffer_renderer test passed");
		end else begin
			$display("glyph_to_framebuffer_renderer test failed");
		end
		$finish;
	end
endmodule
